[hdl/irc_message_line_tokenizer_top_assert.svh]
// Assertion macros for the message line tokenizer checker.
`ifndef IRC_MESSAGE_LINE_TOKENIZER_TOP_ASSERT_SVH
`define IRC_MESSAGE_LINE_TOKENIZER_TOP_ASSERT_SVH

// Checked only while out of reset.
`define IRC_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define IRC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/irc_mlt_pkg.sv]
// Types and constants shared by the message line tokenizer files.
package irc_mlt_pkg;

	localparam int unsigned PARAM_LIMIT = 15;
	localparam int unsigned EFF_LIMIT = (PARAM_LIMIT > 15) ? 15 : PARAM_LIMIT;
	localparam logic [3:0] LIMIT = 4'(EFF_LIMIT);

	localparam logic [7:0] COLON = 8'h3A;
	localparam logic [7:0] SPACE = 8'h20;

	typedef enum logic [2:0] {
		PH_START    = 3'd0,
		PH_PREFIX   = 3'd1,
		PH_PRESPACE = 3'd2,
		PH_CMD      = 3'd3,
		PH_GAP      = 3'd4,
		PH_MIDDLE   = 3'd5,
		PH_TRAIL    = 3'd6,
		PH_DEAD     = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		ROLE_DROP    = 3'd0,
		ROLE_CMD     = 3'd1,
		ROLE_PARAM   = 3'd2,
		ROLE_OPENER  = 3'd3,
		ROLE_SUMMARY = 3'd4
	} role_t;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_EOL  = 1'b1;

	function automatic logic [7:0] upcase(input logic [7:0] b);
		upcase = (b >= 8'h61 && b <= 8'h7A) ? (b - 8'h20) : b;
	endfunction

endpackage

[hdl/irc_message_line_tokenizer_top.sv]
// Message line tokenizer: phase machine tagging each line byte with its role.
//
// Usage:
//   Input channel (in_valid/in_ready): one beat per line byte (action 0) and
//   one end-of-line beat (action 1) after the last byte; no terminator bytes.
//   Output channel (out_valid/out_ready): exactly one result beat for every
//   input beat, in order. Byte beats carry the byte, its role (dropped,
//   command, parameter, trailing opener), a token-start flag and the
//   parameter index; the end-of-line beat carries the summary (line_valid,
//   param_count) and returns the phase machine to line start.
//   An accepted beat moves from the input register to the result register.
//   Throughput: one beat per cycle while not stalled, set by the single
//   phase machine update between the input and the result register.
//   Stall: while out_ready is low and a result waits, the pipeline holds and
//   in_ready drops once the input register is also full; nothing is lost.
//   Reset: arst_n clears both valid flags and puts the machine at line start
//   with no parameters and no command seen.
module irc_message_line_tokenizer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [2:0] role,
	output logic       token_start,
	output logic [3:0] param_index,
	output logic       line_valid,
	output logic [3:0] param_count
);
	import irc_mlt_pkg::*;

	logic       valid_s1;
	logic       action_s1;
	logic [7:0] byte_s1;

	phase_t     phase_q, phase_d;
	logic [3:0] params_q, params_d;
	logic       cmd_seen_q, cmd_seen_d;

	logic       out_valid_q;
	logic [7:0] out_byte_q, r_byte;
	role_t      role_q, r_role;
	logic       start_q, r_start;
	logic [3:0] index_q, r_index;
	logic       lvalid_q, r_lvalid;
	logic [3:0] count_q, r_count;

	logic       advance;
	logic [3:0] cur;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign cur      = (params_q == 4'd0) ? 4'd0 : params_q - 4'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1 <= action;
			byte_s1   <= in_byte;
		end
	end

	// next state
	always_comb begin
		phase_d    = phase_q;
		params_d   = params_q;
		cmd_seen_d = cmd_seen_q;
		if (action_s1 == ACT_EOL) begin
			phase_d    = PH_START;
			params_d   = 4'd0;
			cmd_seen_d = 1'b0;
		end else begin
			unique case (phase_q)
				PH_START: begin
					if (byte_s1 == COLON) begin
						phase_d = PH_PREFIX;
					end else if (byte_s1 == SPACE) begin
						phase_d = PH_DEAD;
					end else begin
						phase_d    = PH_CMD;
						cmd_seen_d = 1'b1;
					end
				end
				PH_PREFIX: begin
					if (byte_s1 == SPACE) begin
						phase_d = PH_PRESPACE;
					end
				end
				PH_PRESPACE: begin
					if (byte_s1 != SPACE) begin
						phase_d    = PH_CMD;
						cmd_seen_d = 1'b1;
					end
				end
				PH_CMD: begin
					if (byte_s1 == SPACE) begin
						phase_d = PH_GAP;
					end
				end
				PH_GAP: begin
					if (byte_s1 != SPACE) begin
						if (params_q >= LIMIT) begin
							phase_d = PH_DEAD;
						end else begin
							params_d = params_q + 4'd1;
							phase_d  = (byte_s1 == COLON) ? PH_TRAIL : PH_MIDDLE;
						end
					end
				end
				PH_MIDDLE: begin
					if (byte_s1 == SPACE) begin
						phase_d = PH_GAP;
					end
				end
				PH_TRAIL, PH_DEAD: begin
					phase_d = phase_q;
				end
				default: phase_d = PH_DEAD;
			endcase
		end
	end

	// result fields
	always_comb begin
		r_byte   = byte_s1;
		r_role   = ROLE_DROP;
		r_start  = 1'b0;
		r_index  = 4'd0;
		r_lvalid = 1'b0;
		r_count  = 4'd0;
		if (action_s1 == ACT_EOL) begin
			r_byte   = 8'd0;
			r_role   = ROLE_SUMMARY;
			r_lvalid = cmd_seen_q;
			r_count  = params_q;
		end else begin
			unique case (phase_q)
				PH_START: begin
					if (byte_s1 != COLON && byte_s1 != SPACE) begin
						r_byte = upcase(byte_s1);
						r_role = ROLE_CMD;
					end
				end
				PH_PRESPACE, PH_CMD: begin
					if (byte_s1 != SPACE) begin
						r_byte = upcase(byte_s1);
						r_role = ROLE_CMD;
					end
				end
				PH_GAP: begin
					if (byte_s1 != SPACE && params_q < LIMIT) begin
						r_role  = (byte_s1 == COLON) ? ROLE_OPENER : ROLE_PARAM;
						r_start = 1'b1;
						r_index = params_q;
					end
				end
				PH_MIDDLE: begin
					if (byte_s1 != SPACE) begin
						r_role  = ROLE_PARAM;
						r_index = cur;
					end
				end
				PH_TRAIL: begin
					r_role  = ROLE_PARAM;
					r_index = cur;
				end
				PH_PREFIX, PH_DEAD: begin
					r_role = ROLE_DROP;
				end
				default: r_role = ROLE_DROP;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			params_q    <= 4'd0;
			cmd_seen_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				phase_q    <= phase_d;
				params_q   <= params_d;
				cmd_seen_q <= cmd_seen_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_byte_q <= r_byte;
			role_q     <= r_role;
			start_q    <= r_start;
			index_q    <= r_index;
			lvalid_q   <= r_lvalid;
			count_q    <= r_count;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign role        = role_q;
	assign token_start = start_q;
	assign param_index = index_q;
	assign line_valid  = lvalid_q;
	assign param_count = count_q;

endmodule

[hdl/irc_mlt_checker.sv]
// Port-level checks for the message line tokenizer, bound to the top level.
`include "irc_message_line_tokenizer_top_assert.svh"

module irc_mlt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       action,
	input logic [7:0] in_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic [2:0] role,
	input logic       token_start,
	input logic [3:0] param_index,
	input logic       line_valid,
	input logic [3:0] param_count
);
	import irc_mlt_pkg::*;

	// a stalled result beat holds
	`IRC_ASSERT(a_stall_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(role) && $stable(param_index), "result beat changed while stalled")

	// summary fields only on the summary beat
	`IRC_ASSERT(a_summary_only, clk, arst_n, out_valid && role != ROLE_SUMMARY |-> !line_valid && param_count == 4'd0, "summary fields set on a byte beat")

	// trailing opener is a colon that starts a token
	`IRC_ASSERT(a_opener, clk, arst_n, out_valid && role == ROLE_OPENER |-> token_start && out_byte == COLON, "bad trailing opener")

	// command bytes are never lower case
	`IRC_ASSERT(a_cmd_upper, clk, arst_n, out_valid && role == ROLE_CMD |-> !(out_byte >= 8'h61 && out_byte <= 8'h7A), "lower-case command byte")

	// no result while reset is held
	`IRC_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !out_valid, "result valid during reset")

endmodule

bind irc_message_line_tokenizer_top irc_mlt_checker u_irc_mlt_checker (.*);
